// File: hw/rtl/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types and constants for the HSL colour adjuster: fixed-point widths,
// register indexes and the per-pixel sideband carried down the pipeline.
// ----------------------------------------------------------------------------
package hca_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_FACTOR = 2'd2;

    localparam logic signed [9:0] HUE_SHIFT_RST = 10'sd0;
    localparam logic [15:0] SAT_FACTOR_RST = 16'd4096;
    localparam logic [15:0] LIGHT_FACTOR_RST = 16'd4096;

    // Divider: 17 quotient bits, 28-bit partial remainder, 11-bit divisor
    localparam int unsigned DIV_QBITS = 17;
    localparam int unsigned DIV_RW = 28;
    localparam int unsigned DIV_DW = 11;
    localparam int unsigned DIV_LANES = 2;
    localparam int unsigned LANE_S = 0;
    localparam int unsigned LANE_H = 1;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [22:0] RECIP_45 = 23'd5965233;
    localparam int unsigned RECIP_SHIFT = 28;
    // Reciprocal of 255 with 32 fraction bits, rounded up
    localparam logic [24:0] LIGHT_RECIP = 25'd16843010;

    // Stages after the divider and total depth of the sideband line
    localparam int unsigned POST_STAGES = 7;
    localparam int unsigned PIPE_LAST = DIV_QBITS + POST_STAGES;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       grey;
    } side_t;

endpackage

// File: hw/rtl/hsl_color_adjust_top.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust_top
// Pipelined RGBA pixel adjuster working in HSL space.
//
// Usage:
//   Pixel channel: a pixel is taken at every rising edge with start high and
//   busy low. busy is always low, so one pixel may enter on every clock.
//   Result channel: done is high for one cycle with red/green/blue/alpha_out;
//   the receiver takes it in that cycle and cannot hold it off.
//   Throughput is one pixel per clock; the result leaves after the input
//   register, the 17-stage restoring divider (one quotient bit per stage)
//   that forms saturation and hue, and the post-divider stages; lightness is
//   formed by a reciprocal multiply and travels beside the divider.
//   Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. Index 0 hue_shift, 1 sat_factor,
//   2 light_factor. Write only while no pixel is in flight; the derived hue
//   offset is registered in hue_mod_reg, hue_prod_reg and then sh_reg.
//   Reset: clears the pipeline valid bits and returns the registers to hue
//   shift 0 and both factors 1.0.
// ----------------------------------------------------------------------------
module hsl_color_adjust_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       red_in,
    input  logic [7:0]                       green_in,
    input  logic [7:0]                       blue_in,
    input  logic [7:0]                       alpha_in,
    output logic                             done,
    output logic [7:0]                       red_out,
    output logic [7:0]                       green_out,
    output logic [7:0]                       blue_out,
    output logic [7:0]                       alpha_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hca_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned QB = hca_pkg::DIV_QBITS;
    localparam int unsigned RW = hca_pkg::DIV_RW;
    localparam int unsigned DW = hca_pkg::DIV_DW;
    localparam int unsigned NL = hca_pkg::DIV_LANES;
    localparam int unsigned PL = hca_pkg::PIPE_LAST;
    localparam int unsigned LAT = PL + 2;

    // ------------------------------------------------------------------
    // Configuration registers and derived hue offset
    // ------------------------------------------------------------------
    logic signed [9:0] hue_shift_reg;
    logic [15:0]       sat_factor_reg;
    logic [15:0]       light_factor_reg;
    logic [8:0]        hue_mod_reg;
    logic [44:0]       hue_prod_reg;
    logic [15:0]       sh_reg;

    logic signed [10:0] hs_ext;
    logic signed [10:0] hue_mod_next;
    logic [21:0]        hue_y;

    assign cfg_ready = 1'b1;
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg <= hca_pkg::HUE_SHIFT_RST;
            sat_factor_reg <= hca_pkg::SAT_FACTOR_RST;
            light_factor_reg <= hca_pkg::LIGHT_FACTOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hca_pkg::CFG_HUE_SHIFT:    hue_shift_reg <= cfg_data[9:0];
                hca_pkg::CFG_SAT_FACTOR:   sat_factor_reg <= cfg_data;
                hca_pkg::CFG_LIGHT_FACTOR: light_factor_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        hs_ext = 11'(hue_shift_reg);
        if (hs_ext < -11'sd360)
            hue_mod_next = hs_ext + 11'sd720;
        else if (hs_ext < 11'sd0)
            hue_mod_next = hs_ext + 11'sd360;
        else if (hs_ext >= 11'sd360)
            hue_mod_next = hs_ext - 11'sd360;
        else
            hue_mod_next = hs_ext;
        hue_y = {hue_mod_reg, 13'd0} + 22'd22;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_mod_reg <= '0;
            hue_prod_reg <= '0;
            sh_reg <= '0;
        end
        else
        begin
            hue_mod_reg <= hue_mod_next[8:0];
            hue_prod_reg <= 45'(hue_y) * 45'(hca_pkg::RECIP_45);
            sh_reg <= hue_prod_reg[hca_pkg::RECIP_SHIFT +: 16];
        end
    end

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] in_red_reg;
    logic [7:0] in_green_reg;
    logic [7:0] in_blue_reg;
    logic [7:0] in_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_red_reg <= red_in;
            in_green_reg <= green_in;
            in_blue_reg <= blue_in;
            in_alpha_reg <= alpha_in;
        end
    end

    // ------------------------------------------------------------------
    // Divider set-up: max, min, sextant position and the dividends
    // ------------------------------------------------------------------
    logic [7:0]    mx;
    logic [7:0]    mn;
    logic [7:0]    dlt;
    logic [8:0]    sum;
    logic [10:0]   d6;
    logic [10:0]   tpos;
    logic [7:0]    den_s;
    logic [RW-1:0] rem0 [NL];
    logic [DW-1:0] dvs0 [NL];

    always_comb
    begin
        mx = (in_red_reg > in_green_reg) ? in_red_reg : in_green_reg;
        if (in_blue_reg > mx)
            mx = in_blue_reg;
        mn = (in_red_reg < in_green_reg) ? in_red_reg : in_green_reg;
        if (in_blue_reg < mn)
            mn = in_blue_reg;
        dlt = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        d6 = {1'b0, dlt, 2'b00} + {2'b00, dlt, 1'b0};
        if (in_red_reg == mx)
        begin
            if (in_green_reg >= in_blue_reg)
                tpos = {3'd0, in_green_reg} - {3'd0, in_blue_reg};
            else
                tpos = d6 + {3'd0, in_green_reg} - {3'd0, in_blue_reg};
        end
        else if (in_green_reg == mx)
            tpos = {2'd0, dlt, 1'b0} + {3'd0, in_blue_reg} - {3'd0, in_red_reg};
        else
            tpos = {1'b0, dlt, 2'b00} + {3'd0, in_red_reg} - {3'd0, in_green_reg};
        den_s = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

        rem0[hca_pkg::LANE_S] = RW'({dlt, 16'd0}) + RW'(den_s[7:1]);
        dvs0[hca_pkg::LANE_S] = DW'(den_s);
        rem0[hca_pkg::LANE_H] = RW'({tpos, 16'd0}) + RW'({dlt, 1'b0}) + RW'(dlt);
        dvs0[hca_pkg::LANE_H] = d6;
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, two lanes; lightness
    // by reciprocal multiply alongside
    // ------------------------------------------------------------------
    logic [RW-1:0]        rem_reg [QB+1][NL];
    logic [DW-1:0]        dvs_reg [QB+1][NL];
    logic [QB-1:0]        quo_reg [QB+1][NL];
    logic [RW:0]          trial   [QB][NL];
    logic                 vld_reg [PL+1];
    hca_pkg::side_t       side_reg [PL+1];
    logic [8:0]           lsum_reg;
    logic [15:0]          lz_reg;
    logic [16:0]          lit_reg [QB];
    logic [40:0]          lprod;

    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            for (int ln = 0; ln < NL; ln++)
            begin
                trial[j][ln] = {1'b0, rem_reg[j][ln]}
                             - ((RW+1)'(dvs_reg[j][ln]) << (QB - 1 - j));
            end
        end
        lprod = 41'(lz_reg) * 41'(hca_pkg::LIGHT_RECIP);
    end

    always_ff @(posedge clk)
    begin
        for (int ln = 0; ln < NL; ln++)
        begin
            rem_reg[0][ln] <= rem0[ln];
            dvs_reg[0][ln] <= dvs0[ln];
            quo_reg[0][ln] <= '0;
        end
        for (int j = 0; j < QB; j++)
        begin
            for (int ln = 0; ln < NL; ln++)
            begin
                rem_reg[j+1][ln] <= trial[j][ln][RW] ? rem_reg[j][ln] : trial[j][ln][RW-1:0];
                dvs_reg[j+1][ln] <= dvs_reg[j][ln];
                quo_reg[j+1][ln] <= {quo_reg[j][ln][QB-2:0], ~trial[j][ln][RW]};
            end
        end
        lsum_reg <= sum;
        lz_reg <= {sum, 7'd0} + 16'd127;
        lit_reg[0] <= 17'({lsum_reg, 7'd0}) + 17'(lprod[40:32]);
        for (int j = 0; j < QB - 1; j++)
            lit_reg[j+1] <= lit_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= PL; j++)
                vld_reg[j] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld_reg;
            for (int j = 0; j < PL; j++)
                vld_reg[j+1] <= vld_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{alpha: in_alpha_reg, red: in_red_reg, green: in_green_reg,
                         blue: in_blue_reg, grey: (dlt == 8'd0)};
        for (int j = 0; j < PL; j++)
            side_reg[j+1] <= side_reg[j];
    end

    // ------------------------------------------------------------------
    // Post-divider stages
    // ------------------------------------------------------------------
    logic [15:0] hue1_reg, hue2_reg, hue3_reg, hue4_reg;
    logic [16:0] sat1_reg, lit1_reg;
    logic [32:0] sprod2_reg, lprod2_reg;
    logic [16:0] s3_reg, l3_reg;
    logic [34:0] m3_reg;
    logic signed [19:0] q4_reg, p4_reg;
    logic signed [19:0] p5_reg, q5_reg;
    logic [2:0]         e5_reg [3];
    logic signed [38:0] prod5_reg [3];
    logic [39:0]        v6_reg [3];
    logic [7:0]         ch7_reg [3];

    logic        shift_on;
    logic [16:0] q_sat;
    logic [16:0] hue1_next;
    logic [33:0] srnd, lrnd;
    logic [16:0] s3_next, l3_next;
    logic [17:0] mop3;
    logic [19:0] rnd4;
    logic signed [19:0] q4_next;

    always_comb
    begin
        shift_on = (hue_shift_reg != 10'sd0);
        q_sat = (quo_reg[QB][hca_pkg::LANE_S] > hca_pkg::ONE_Q16)
              ? hca_pkg::ONE_Q16 : quo_reg[QB][hca_pkg::LANE_S];
        hue1_next = 17'(quo_reg[QB][hca_pkg::LANE_H][15:0]) + 17'(sh_reg);

        srnd = 34'(sprod2_reg) + 34'd2048;
        lrnd = 34'(lprod2_reg) + 34'd2048;
        s3_next = (srnd[33:12] > 22'(hca_pkg::ONE_Q16)) ? hca_pkg::ONE_Q16 : srnd[28:12];
        l3_next = (lrnd[33:12] > 22'(hca_pkg::ONE_Q16)) ? hca_pkg::ONE_Q16 : lrnd[28:12];
        mop3 = (l3_next < hca_pkg::HALF_Q16) ? (18'(hca_pkg::ONE_Q16) + 18'(s3_next))
                                             : 18'(s3_next);

        rnd4 = 20'((36'(m3_reg) + 36'd32768) >> 16);
        if (l3_reg < hca_pkg::HALF_Q16)
            q4_next = signed'(rnd4);
        else
            q4_next = signed'(20'(l3_reg) + 20'(s3_reg) - rnd4);
    end

    always_ff @(posedge clk)
    begin
        if (side_reg[QB].grey)
        begin
            hue1_reg <= shift_on ? sh_reg : 16'd0;
            sat1_reg <= shift_on ? hca_pkg::HALF_Q16 : 17'd0;
        end
        else
        begin
            hue1_reg <= hue1_next[15:0];
            sat1_reg <= q_sat;
        end
        lit1_reg <= lit_reg[QB-1];

        hue2_reg <= hue1_reg;
        sprod2_reg <= 33'(sat1_reg) * 33'(sat_factor_reg);
        lprod2_reg <= 33'(lit1_reg) * 33'(light_factor_reg);

        hue3_reg <= hue2_reg;
        s3_reg <= s3_next;
        l3_reg <= l3_next;
        m3_reg <= 35'(l3_next) * 35'(mop3);

        hue4_reg <= hue3_reg;
        q4_reg <= q4_next;
        p4_reg <= signed'({2'b00, l3_reg, 1'b0}) - q4_next;
    end

    // ------------------------------------------------------------------
    // Back to RGB, one lane per channel (red k=2, green k=0, blue k=4)
    // ------------------------------------------------------------------
    logic [19:0]        u5 [3];
    logic [2:0]         kk [3];
    logic [16:0]        frac5 [3];
    logic signed [20:0] diff5;
    logic signed [40:0] v6 [3];
    logic [48:0]        w7 [3];

    always_comb
    begin
        kk[0] = 3'd2;
        kk[1] = 3'd0;
        kk[2] = 3'd4;
        diff5 = 21'(q4_reg) - 21'(p4_reg);
        for (int c = 0; c < 3; c++)
        begin
            u5[c] = {2'b00, hue4_reg, 2'b00} + {3'b000, hue4_reg, 1'b0}
                  + {1'b0, kk[c], 16'd0};
            if (u5[c] >= 20'd393216)
                u5[c] = u5[c] - 20'd393216;
            frac5[c] = (u5[c][18:16] == 3'd0) ? {1'b0, u5[c][15:0]}
                                             : (hca_pkg::ONE_Q16 - {1'b0, u5[c][15:0]});
        end
        for (int c = 0; c < 3; c++)
        begin
            case (e5_reg[c])
                3'd0, 3'd3: v6[c] = (41'(p5_reg) <<< 16) + 41'(prod5_reg[c]);
                3'd1, 3'd2: v6[c] = 41'(q5_reg) <<< 16;
                default:    v6[c] = 41'(p5_reg) <<< 16;
            endcase
            w7[c] = ({9'd0, v6_reg[c]} << 8) - {9'd0, v6_reg[c]} + 49'h0_8000_0000;
        end
    end

    always_ff @(posedge clk)
    begin
        p5_reg <= p4_reg;
        q5_reg <= q4_reg;
        for (int c = 0; c < 3; c++)
        begin
            e5_reg[c] <= u5[c][18:16];
            prod5_reg[c] <= 39'(diff5) * 39'(signed'({1'b0, frac5[c]}));
            v6_reg[c] <= v6[c][40] ? 40'd0 : v6[c][39:0];
            ch7_reg[c] <= (w7[c][48:32] > 17'd255) ? 8'd255 : w7[c][39:32];
        end
    end

    // ------------------------------------------------------------------
    // Result ports; transparent pixels pass unchanged
    // ------------------------------------------------------------------
    assign done = vld_reg[PL];
    assign alpha_out = side_reg[PL].alpha;
    assign red_out = (side_reg[PL].alpha == 8'd0) ? side_reg[PL].red : ch7_reg[0];
    assign green_out = (side_reg[PL].alpha == 8'd0) ? side_reg[PL].green : ch7_reg[1];
    assign blue_out = (side_reg[PL].alpha == 8'd0) ? side_reg[PL].blue : ch7_reg[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted transaction");

    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction lost in pipeline");

    a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> alpha_out == $past(alpha_in, LAT))
        else $error("alpha not carried with its pixel");

    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && alpha_out == 8'd0) |-> (red_out == $past(red_in, LAT)
            && green_out == $past(green_in, LAT) && blue_out == $past(blue_in, LAT)))
        else $error("transparent pixel altered");

endmodule

// File: verif/hsl_color_adjust_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsl_color_adjust_top_tb
// Self-checking bench for the HSL pixel adjuster. Pixels are sent through the
// start/busy channel with random gaps. Each one is predicted in fixed point and
// queued, and every done transaction is compared field by field with the
// oldest prediction. Several register settings are used, the extremes among
// them, and registers are written only while no pixel is in flight.
// ----------------------------------------------------------------------------
module hsl_color_adjust_top_tb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct {
        pixel_t pix;
        bit     known;
        pixel_t res;
    } pixel_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       done;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [hca_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hca_pkg::CFG_DATA_W-1:0] cfg_data;

    int          shift_deg;
    int unsigned sat_gain;
    int unsigned light_gain;
    pixel_t      pixel_q[$];
    int          fail_count;

    hsl_color_adjust_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned gain_clip(longint unsigned x, longint unsigned k);
        longint unsigned v;
        v = (x * k + 2048) >> 12;
        return (v > 65536) ? 65536 : v;
    endfunction

    function automatic logic [7:0] hue_channel(longint unsigned h, longint unsigned k,
                                                longint p, longint q);
        longint unsigned u;
        longint unsigned e;
        longint          f;
        longint          v;
        longint unsigned r;
        u = (h * 6 + k * 65536) % 393216;
        e = u >> 16;
        f = longint'(u & 16'hFFFF);
        if (e == 0)
            v = p * 65536 + (q - p) * f;
        else if (e <= 2)
            v = q * 65536;
        else if (e == 3)
            v = p * 65536 + (q - p) * (65536 - f);
        else
            v = p * 65536;
        if (v < 0)
            v = 0;
        r = (longint'(v) * 255 + 64'h8000_0000) >> 32;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t px);
        pixel_t          o;
        longint          r;
        longint          g;
        longint          b;
        longint          mx;
        longint          mn;
        longint          d;
        longint          s;
        longint          m;
        longint          t;
        longint unsigned lum;
        longint unsigned sat;
        longint unsigned hue;
        longint unsigned sh;
        longint unsigned den;
        longint          p;
        longint          q;
        o = px;
        if (px.alpha == 0)
            return o;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        d = mx - mn;
        s = mx + mn;
        lum = (s * 65536 + 255) / 510;
        m = ((shift_deg % 360) + 360) % 360;
        sh = (m * 65536 + 180) / 360;
        sat = 0;
        hue = 0;
        if (d > 0)
        begin
            den = (s <= 255) ? s : 510 - s;
            sat = (d * 65536 + den / 2) / den;
            if (sat > 65536) sat = 65536;
            if (r == mx)
            begin
                t = g - b;
                if (t < 0) t += 6 * d;
            end
            else if (g == mx)
                t = 2 * d + (b - r);
            else
                t = 4 * d + (r - g);
            hue = ((t * 65536 + 3 * d) / (6 * d)) & 16'hFFFF;
            hue = (hue + sh) & 16'hFFFF;
            sat = gain_clip(sat, sat_gain);
        end
        else if (shift_deg != 0)
        begin
            hue = sh & 16'hFFFF;
            sat = gain_clip(32768, sat_gain);
        end
        lum = gain_clip(lum, light_gain);
        if (lum < 32768)
            q = (longint'(lum) * longint'(65536 + sat) + 32768) >>> 16;
        else
            q = longint'(lum) + longint'(sat) - ((longint'(lum * sat) + 32768) >>> 16);
        p = 2 * longint'(lum) - q;
        o.red = hue_channel(hue, 2, p, q);
        o.green = hue_channel(hue, 0, p, q);
        o.blue = hue_channel(hue, 4, p, q);
        return o;
    endfunction

    task automatic write_reg(logic [hca_pkg::CFG_IDX_W-1:0] idx,
                             logic [hca_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hca_pkg::CFG_HUE_SHIFT:    shift_deg = int'($signed(val[9:0]));
            hca_pkg::CFG_SAT_FACTOR:   sat_gain = val;
            hca_pkg::CFG_LIGHT_FACTOR: light_gain = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(int hs, int unsigned sf, int unsigned lf);
        int w;
        start <= 1'b0;
        w = 0;
        while (pixel_q.size() != 0 && w < 100000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (30) @(posedge clk);
        write_reg(hca_pkg::CFG_HUE_SHIFT, hca_pkg::CFG_DATA_W'(hs & 10'h3FF));
        write_reg(hca_pkg::CFG_SAT_FACTOR, sf[15:0]);
        write_reg(hca_pkg::CFG_LIGHT_FACTOR, lf[15:0]);
        cfg_valid <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic send_pixel(pixel_t px, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        red_in <= px.red;
        green_in <= px.green;
        blue_in <= px.blue;
        alpha_in <= px.alpha;
        do
            @(posedge clk);
        while (busy);
        pixel_q.insert(pixel_q.size(), adjust_pixel(px));
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     mode;
        px = $urandom;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            px.alpha = 8'd0;
        else if (mode == 1)
        begin
            px.green = px.red;
            px.blue = px.red;
        end
        else if (mode == 2)
            px.green = px.red;
        return px;
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("result with no pixel outstanding");
                fail_count++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (red_out !== want.red)
                begin
                    $error("red_out expected %0d actual %0d", want.red, red_out);
                    fail_count++;
                end
                if (green_out !== want.green)
                begin
                    $error("green_out expected %0d actual %0d", want.green, green_out);
                    fail_count++;
                end
                if (blue_out !== want.blue)
                begin
                    $error("blue_out expected %0d actual %0d", want.blue, blue_out);
                    fail_count++;
                end
                if (alpha_out !== want.alpha)
                begin
                    $error("alpha_out expected %0d actual %0d", want.alpha, alpha_out);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        pixel_row_t rows[$];
        pixel_t     got;
        int         hs_set[6];
        int         sf_set[6];
        int         lf_set[6];
        int         w;

        rst_n = 1'b0;
        start = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        alpha_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        shift_deg = 0;
        sat_gain = 4096;
        light_gain = 4096;

        rows.insert(rows.size(), '{'{8'd0, 8'd0, 8'd0, 8'd255}, 1'b1,
                                   '{8'd0, 8'd0, 8'd0, 8'd255}});
        rows.insert(rows.size(), '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
                                   '{8'd255, 8'd255, 8'd255, 8'd255}});
        rows.insert(rows.size(), '{'{8'd255, 8'd0, 8'd0, 8'd1}, 1'b1,
                                   '{8'd255, 8'd0, 8'd0, 8'd1}});
        rows.insert(rows.size(), '{'{8'd0, 8'd255, 8'd0, 8'd128}, 1'b1,
                                   '{8'd0, 8'd255, 8'd0, 8'd128}});
        rows.insert(rows.size(), '{'{8'd0, 8'd0, 8'd255, 8'd255}, 1'b1,
                                   '{8'd0, 8'd0, 8'd255, 8'd255}});
        rows.insert(rows.size(), '{'{8'd12, 8'd200, 8'd77, 8'd0}, 1'b1,
                                   '{8'd12, 8'd200, 8'd77, 8'd0}});
        rows.insert(rows.size(), '{'{8'd255, 8'd255, 8'd255, 8'd0}, 1'b1,
                                   '{8'd255, 8'd255, 8'd255, 8'd0}});
        rows.insert(rows.size(), '{'{8'd128, 8'd128, 8'd128, 8'd255}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd255, 8'd255, 8'd0, 8'd255}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd0, 8'd255, 8'd255, 8'd255}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd200, 8'd100, 8'd150, 8'd170}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd1, 8'd0, 8'd0, 8'd255}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd254, 8'd255, 8'd255, 8'd255}, 1'b0, '0});
        rows.insert(rows.size(), '{'{8'd85, 8'd170, 8'd170, 8'd85}, 1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_pixel(rows[i].pix, $urandom_range(0, 3));
            if (rows[i].known && adjust_pixel(rows[i].pix) != rows[i].res)
            begin
                $error("table row %0d disagrees with prediction", i);
                fail_count++;
            end
        end

        hs_set = '{360, -360, 359, -359, 511, -512};
        sf_set = '{0, 65535, 2048, 8192, 4096, 5000};
        lf_set = '{65535, 0, 4096, 2048, 6000, 3000};
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph < 6)
                set_regs(hs_set[ph], sf_set[ph], lf_set[ph]);
            else
                set_regs($urandom_range(0, 720) - 360, $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            for (int n = 0; n < 120; n++)
            begin
                got = rand_pixel();
                if (n < 40)
                    send_pixel(got, 0);
                else
                    send_pixel(got, $urandom_range(0, 16));
            end
            // a grey pixel under the current shift
            send_pixel('{8'd77, 8'd77, 8'd77, 8'd255}, 0);
        end

        start <= 1'b0;
        w = 0;
        while (pixel_q.size() != 0 && w < 100000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pixel_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
